// ===== rtl/amof_pkg.sv =====
// ----------------------------------------------------------------------------
// amof_pkg
// Types and codes shared by the addressing mode operand fetch block.
// ----------------------------------------------------------------------------
package amof_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OP1   = 3'd1,
    PH_DATA  = 3'd2,
    PH_ABSHI = 3'd3,
    PH_PTRLO = 3'd4,
    PH_PTRHI = 3'd5
  } phase_t;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ZPY  = 4'd3;
  localparam logic [3:0] MODE_ABS  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_INDX = 4'd7;
  localparam logic [3:0] MODE_INDY = 4'd8;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic [1:0] ST_REQUEST = 2'd0;
  localparam logic [1:0] ST_OPERAND = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  mode;
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  zp_ptr;
    logic [7:0]  low;
  } fetch_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_addr;
    logic [7:0]  operand;
    logic [15:0] next_pc;
  } fetch_result_t;

endpackage

// ===== rtl/amof_step.sv =====
// ----------------------------------------------------------------------------
// amof_step
// One step of the operand fetch sequence: from the held state and one
// transaction, form the next state and the result.
// ----------------------------------------------------------------------------
module amof_step (
  input  amof_pkg::fetch_state_t  state,
  input  logic                    req_type,
  input  logic [3:0]              mode,
  input  logic [15:0]             pc,
  input  logic [7:0]              index_x,
  input  logic [7:0]              index_y,
  input  logic [7:0]              read_data,
  output amof_pkg::fetch_state_t  state_next,
  output amof_pkg::fetch_result_t result
);

  logic        busy;
  logic [7:0]  idx_abs;
  logic [7:0]  idx_ind;
  logic [15:0] addr_abs;
  logic [15:0] addr_ind;

  assign busy = (state.phase == amof_pkg::PH_OP1)   || (state.phase == amof_pkg::PH_DATA)  ||
                (state.phase == amof_pkg::PH_ABSHI) || (state.phase == amof_pkg::PH_PTRLO) ||
                (state.phase == amof_pkg::PH_PTRHI);

  assign idx_abs = (state.mode == amof_pkg::MODE_ABSX) ? state.x :
                   (state.mode == amof_pkg::MODE_ABSY) ? state.y : 8'd0;
  assign idx_ind = (state.mode == amof_pkg::MODE_INDY) ? state.y : 8'd0;

  // Pointer and absolute targets wrap at 16 bits
  assign addr_abs = {read_data, 8'd0} + {8'd0, state.low} + {8'd0, idx_abs};
  assign addr_ind = {read_data, 8'd0} + {8'd0, state.low} + {8'd0, idx_ind};

  always_comb begin
    state_next = state;
    result     = '{status: amof_pkg::ST_IGNORED, read_addr: 16'd0,
                   operand: 8'd0, next_pc: 16'd0};
    if (req_type == amof_pkg::REQ_START) begin
      if (!busy && (mode <= amof_pkg::MODE_INDY)) begin
        state_next.mode  = mode;
        state_next.x     = index_x;
        state_next.y     = index_y;
        state_next.pc    = pc + 16'd1;
        state_next.phase = amof_pkg::PH_OP1;
        result.status    = amof_pkg::ST_REQUEST;
        result.read_addr = pc;
      end
    end else if (busy) begin
      result.status = amof_pkg::ST_REQUEST;
      unique case (state.phase)
        amof_pkg::PH_OP1: begin
          unique case (state.mode)
            amof_pkg::MODE_IMM: begin
              state_next.phase = amof_pkg::PH_IDLE;
              result.status    = amof_pkg::ST_OPERAND;
              result.operand   = read_data;
              result.next_pc   = state.pc;
            end
            amof_pkg::MODE_ZP: begin
              state_next.phase = amof_pkg::PH_DATA;
              result.read_addr = {8'd0, read_data};
            end
            amof_pkg::MODE_ZPX: begin
              state_next.phase = amof_pkg::PH_DATA;
              result.read_addr = {8'd0, read_data + state.x};
            end
            amof_pkg::MODE_ZPY: begin
              state_next.phase = amof_pkg::PH_DATA;
              result.read_addr = {8'd0, read_data + state.y};
            end
            amof_pkg::MODE_ABS, amof_pkg::MODE_ABSX, amof_pkg::MODE_ABSY: begin
              state_next.low   = read_data;
              state_next.pc    = state.pc + 16'd1;
              state_next.phase = amof_pkg::PH_ABSHI;
              result.read_addr = state.pc;
            end
            amof_pkg::MODE_INDX: begin
              state_next.zp_ptr = read_data + state.x;
              state_next.phase  = amof_pkg::PH_PTRLO;
              result.read_addr  = {8'd0, read_data + state.x};
            end
            default: begin
              // Indirect indexed: pointer straight from the operand byte
              state_next.zp_ptr = read_data;
              state_next.phase  = amof_pkg::PH_PTRLO;
              result.read_addr  = {8'd0, read_data};
            end
          endcase
        end
        amof_pkg::PH_ABSHI: begin
          state_next.phase = amof_pkg::PH_DATA;
          result.read_addr = addr_abs;
        end
        amof_pkg::PH_PTRLO: begin
          // High pointer byte wraps within page zero
          state_next.low   = read_data;
          state_next.phase = amof_pkg::PH_PTRHI;
          result.read_addr = {8'd0, state.zp_ptr + 8'd1};
        end
        amof_pkg::PH_PTRHI: begin
          state_next.phase = amof_pkg::PH_DATA;
          result.read_addr = addr_ind;
        end
        default: begin
          state_next.phase = amof_pkg::PH_IDLE;
          result.status    = amof_pkg::ST_OPERAND;
          result.operand   = read_data;
          result.next_pc   = state.pc;
        end
      endcase
    end
  end

endmodule

// ===== rtl/addressing_mode_operand_fetch.sv =====
// ----------------------------------------------------------------------------
// addressing_mode_operand_fetch
// Operand fetch sequencer for the 6502 data addressing modes, with memory
// reads issued as results and answered by read-data transactions.
// ----------------------------------------------------------------------------
// Path: each transaction passes the input register, then the result register;
// the sequencer step sits between them.
// Throughput: one transaction per cycle while the output side keeps up.
// Reset: synchronous, clears both pipeline valids and the sequencer state
// to idle with all held values zero.
module addressing_mode_operand_fetch (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  mode,
  input  logic [15:0] pc,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] read_addr,
  output logic [7:0]  operand,
  output logic [15:0] next_pc
);

  logic                    s1_valid;
  logic                    s1_req_type;
  logic [3:0]              s1_mode;
  logic [15:0]             s1_pc;
  logic [7:0]              s1_x;
  logic [7:0]              s1_y;
  logic [7:0]              s1_data;
  logic                    advance;
  amof_pkg::fetch_state_t  state;
  amof_pkg::fetch_state_t  state_next;
  amof_pkg::fetch_result_t result;
  amof_pkg::fetch_result_t res_q;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_type <= req_type;
      s1_mode     <= mode;
      s1_pc       <= pc;
      s1_x        <= index_x;
      s1_y        <= index_y;
      s1_data     <= read_data;
    end
  end

  amof_step u_step (
    .state      (state),
    .req_type   (s1_req_type),
    .mode       (s1_mode),
    .pc         (s1_pc),
    .index_x    (s1_x),
    .index_y    (s1_y),
    .read_data  (s1_data),
    .state_next (state_next),
    .result     (result)
  );

  // Advance the sequencer only when the result register takes the step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: amof_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign status    = res_q.status;
  assign read_addr = res_q.read_addr;
  assign operand   = res_q.operand;
  assign next_pc   = res_q.next_pc;

endmodule

// ===== rtl/amof_checker.sv =====
// ----------------------------------------------------------------------------
// amof_checker
// Port-level checks for the operand fetch block, bound to the top level.
// ----------------------------------------------------------------------------
module amof_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] read_addr,
  input logic [7:0]  operand,
  input logic [15:0] next_pc
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_addr))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == amof_pkg::ST_REQUEST) || (status == amof_pkg::ST_OPERAND) ||
                  (status == amof_pkg::ST_IGNORED))
    else $error("illegal status code");

  a_addr_only_on_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != amof_pkg::ST_REQUEST) |-> read_addr == 16'd0)
    else $error("address on non-request result");

  a_operand_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != amof_pkg::ST_OPERAND) |-> operand == 8'd0 && next_pc == 16'd0)
    else $error("operand on non-operand result");

endmodule

bind addressing_mode_operand_fetch amof_checker u_amof_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .read_addr (read_addr),
  .operand   (operand),
  .next_pc   (next_pc)
);

// ===== tb/addressing_mode_operand_fetch_checker.sv =====
// ----------------------------------------------------------------------------
// addressing_mode_operand_fetch_checker
// Watches both channels of the operand fetch block, runs its own model of the
// fetch sequencer on every accepted input transaction and compares each
// accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module addressing_mode_operand_fetch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  mode,
  input  logic [15:0] pc,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  read_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [15:0] read_addr,
  input  logic [7:0]  operand,
  input  logic [15:0] next_pc,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  amof_pkg::phase_t seq_phase;
  logic [3:0]       seq_mode;
  logic [15:0]      seq_pc;
  logic [7:0]       seq_x;
  logic [7:0]       seq_y;
  logic [7:0]       seq_zp;
  logic [7:0]       seq_low;

  amof_pkg::fetch_result_t awaited_results[$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  // One step of the sequencer: update the held state, return the result.
  function automatic amof_pkg::fetch_result_t next_fetch_result(
      input logic rt, input logic [3:0] md, input logic [15:0] p,
      input logic [7:0] xi, input logic [7:0] yi, input logic [7:0] b);
    amof_pkg::fetch_result_t r;
    logic [7:0]              idx;
    r        = '0;
    r.status = amof_pkg::ST_IGNORED;
    if (rt == amof_pkg::REQ_START) begin
      if (seq_phase == amof_pkg::PH_IDLE && md <= amof_pkg::MODE_INDY) begin
        seq_mode    = md;
        seq_x       = xi;
        seq_y       = yi;
        seq_pc      = p + 16'd1;
        seq_phase   = amof_pkg::PH_OP1;
        r.status    = amof_pkg::ST_REQUEST;
        r.read_addr = p;
      end
    end else if (seq_phase != amof_pkg::PH_IDLE) begin
      r.status = amof_pkg::ST_REQUEST;
      case (seq_phase)
        amof_pkg::PH_OP1: begin
          case (seq_mode)
            amof_pkg::MODE_IMM: begin
              seq_phase = amof_pkg::PH_IDLE;
              r.status  = amof_pkg::ST_OPERAND;
              r.operand = b;
              r.next_pc = seq_pc;
            end
            amof_pkg::MODE_ZP: begin
              r.read_addr = {8'h00, b};
              seq_phase   = amof_pkg::PH_DATA;
            end
            amof_pkg::MODE_ZPX: begin
              r.read_addr = {8'h00, b + seq_x};
              seq_phase   = amof_pkg::PH_DATA;
            end
            amof_pkg::MODE_ZPY: begin
              r.read_addr = {8'h00, b + seq_y};
              seq_phase   = amof_pkg::PH_DATA;
            end
            amof_pkg::MODE_ABS, amof_pkg::MODE_ABSX, amof_pkg::MODE_ABSY: begin
              seq_low     = b;
              r.read_addr = seq_pc;
              seq_pc      = seq_pc + 16'd1;
              seq_phase   = amof_pkg::PH_ABSHI;
            end
            amof_pkg::MODE_INDX: begin
              seq_zp      = b + seq_x;
              r.read_addr = {8'h00, seq_zp};
              seq_phase   = amof_pkg::PH_PTRLO;
            end
            default: begin
              seq_zp      = b;
              r.read_addr = {8'h00, seq_zp};
              seq_phase   = amof_pkg::PH_PTRLO;
            end
          endcase
        end
        amof_pkg::PH_ABSHI: begin
          idx = (seq_mode == amof_pkg::MODE_ABSX) ? seq_x :
                (seq_mode == amof_pkg::MODE_ABSY) ? seq_y : 8'h00;
          r.read_addr = {b, seq_low} + {8'h00, idx};
          seq_phase   = amof_pkg::PH_DATA;
        end
        amof_pkg::PH_PTRLO: begin
          // pointer high byte stays in page zero
          seq_low     = b;
          r.read_addr = {8'h00, seq_zp + 8'd1};
          seq_phase   = amof_pkg::PH_PTRHI;
        end
        amof_pkg::PH_PTRHI: begin
          idx = (seq_mode == amof_pkg::MODE_INDY) ? seq_y : 8'h00;
          r.read_addr = {b, seq_low} + {8'h00, idx};
          seq_phase   = amof_pkg::PH_DATA;
        end
        default: begin
          seq_phase = amof_pkg::PH_IDLE;
          r.status  = amof_pkg::ST_OPERAND;
          r.operand = b;
          r.next_pc = seq_pc;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report(input string field, input logic [15:0] exp_v, input logic [15:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    amof_pkg::fetch_result_t exp_r;
    if (rst) begin
      seq_phase = amof_pkg::PH_IDLE;
      seq_mode  = '0;
      seq_pc    = '0;
      seq_x     = '0;
      seq_y     = '0;
      seq_zp    = '0;
      seq_low   = '0;
      awaited_results.delete();
    end else begin
      // check the result first so a stray one cannot pair with this edge's input
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h addr %h",
                   $time, status, read_addr);
          mismatches++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (status !== exp_r.status)
            report("status", {14'd0, exp_r.status}, {14'd0, status});
          if (read_addr !== exp_r.read_addr)
            report("read_addr", exp_r.read_addr, read_addr);
          if (operand !== exp_r.operand)
            report("operand", {8'd0, exp_r.operand}, {8'd0, operand});
          if (next_pc !== exp_r.next_pc)
            report("next_pc", exp_r.next_pc, next_pc);
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(next_fetch_result(req_type, mode, pc, index_x, index_y,
                                                    read_data));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== tb/addressing_mode_operand_fetch_test.sv =====
// ----------------------------------------------------------------------------
// addressing_mode_operand_fetch_test
// Drives the operand fetch block as a CPU core and its memory would: start
// transactions followed by read-data bytes, plus out-of-phase and malformed
// traffic, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module addressing_mode_operand_fetch_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [3:0]  mode;
  logic [15:0] pc;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  read_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] read_addr;
  logic [7:0]  operand;
  logic [15:0] next_pc;

  int mismatches;
  int outstanding;
  int results_seen;
  int items_sent;
  int fetches_done;
  int stray_items;
  int calm_left;
  int cycles;

  addressing_mode_operand_fetch dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .mode      (mode),
    .pc        (pc),
    .index_x   (index_x),
    .index_y   (index_y),
    .read_data (read_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .read_addr (read_addr),
    .operand   (operand),
    .next_pc   (next_pc)
  );

  addressing_mode_operand_fetch_checker fetch_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .mode         (mode),
    .pc           (pc),
    .index_x      (index_x),
    .index_y      (index_y),
    .read_data    (read_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_addr    (read_addr),
    .operand      (operand),
    .next_pc      (next_pc),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short gaps, the odd long one, and calm stretches with none.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Data bytes a well-formed fetch in this mode consumes.
  function automatic int operand_reads(input logic [3:0] md);
    case (md)
      amof_pkg::MODE_IMM:                                       return 1;
      amof_pkg::MODE_ZP, amof_pkg::MODE_ZPX, amof_pkg::MODE_ZPY:    return 2;
      amof_pkg::MODE_ABS, amof_pkg::MODE_ABSX, amof_pkg::MODE_ABSY: return 3;
      default:                                                  return 4;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one transaction and hold it until accepted; valid stays high
  // across back-to-back transactions.
  task automatic send(input logic rt, input logic [3:0] md, input logic [15:0] p,
                      input logic [7:0] xi, input logic [7:0] yi, input logic [7:0] rd);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rt;
    mode      <= md;
    pc        <= p;
    index_x   <= xi;
    index_y   <= yi;
    read_data <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Unused fields carry random values; the block must ignore them.
  task automatic send_start(input logic [3:0] md, input logic [15:0] p,
                            input logic [7:0] xi, input logic [7:0] yi);
    send(amof_pkg::REQ_START, md, p, xi, yi, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_data(input logic [7:0] b);
    send(amof_pkg::REQ_DATA, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
  endtask

  task automatic run_fetch(input logic [3:0] md, input logic [15:0] p, input logic [7:0] xi,
                           input logic [7:0] yi, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] bytes[4];
    bytes = '{b0, b1, b2, b3};
    send_start(md, p, xi, yi);
    for (int i = 0; i < operand_reads(md); i++) send_data(bytes[i]);
    fetches_done++;
  endtask

  function automatic logic [15:0] rand_pc();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'hFFFE;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    forever begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else if (r < 60) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned r;
    int          k;
    logic [3:0]  md;
    logic [7:0]  b[4];
    cycles       = 0;
    items_sent   = 0;
    fetches_done = 0;
    stray_items  = 0;
    calm_left    = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= amof_pkg::REQ_START;
    mode      <= amof_pkg::MODE_IMM;
    pc        <= '0;
    index_x   <= '0;
    index_y   <= '0;
    read_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Out-of-phase traffic on an idle block: read data, unknown modes.
    send_data(8'hA5);
    send_start(4'd9, 16'h1234, 8'h00, 8'h00);
    send_start(4'd15, 16'hFFFF, 8'hFF, 8'hFF);
    stray_items += 3;

    // Every mode but the indirect ones, with the wrap cases: PC, page zero, 16-bit index.
    run_fetch(amof_pkg::MODE_IMM,  16'hFFFF, 8'h00, 8'h00, 8'h5A, 8'h00, 8'h00, 8'h00);
    run_fetch(amof_pkg::MODE_ZP,   16'h0000, 8'h00, 8'h00, 8'hFF, 8'h3C, 8'h00, 8'h00);
    run_fetch(amof_pkg::MODE_ZPX,  16'h8000, 8'h20, 8'h00, 8'hF0, 8'hC3, 8'h00, 8'h00);
    run_fetch(amof_pkg::MODE_ZPY,  16'h7FFF, 8'h00, 8'hFF, 8'h01, 8'h81, 8'h00, 8'h00);
    run_fetch(amof_pkg::MODE_ABS,  16'hFFFE, 8'h00, 8'h00, 8'h34, 8'h12, 8'h99, 8'h00);
    run_fetch(amof_pkg::MODE_ABSX, 16'h0200, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h00);
    run_fetch(amof_pkg::MODE_ABSY, 16'h4000, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h22, 8'h00);

    // Indexed indirect through $FF, with a start arriving mid-fetch.
    send_start(amof_pkg::MODE_INDX, 16'hC000, 8'h80, 8'h00);
    send_data(8'h7F);
    send_start(amof_pkg::MODE_IMM, 16'h0010, 8'h00, 8'h00);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h77);
    fetches_done++;
    stray_items++;

    run_fetch(amof_pkg::MODE_INDY, 16'hABCD, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hEE);

    while (items_sent < RANDOM_ITEMS + 40) begin
      r  = $urandom_range(0, 99);
      md = 4'($urandom_range(0, 8));
      foreach (b[i]) b[i] = rand_byte();
      if (r < 85) begin
        run_fetch(md, rand_pc(), rand_byte(), rand_byte(), b[0], b[1], b[2], b[3]);
      end else if (r < 90) begin
        send_data(rand_byte());
        stray_items++;
      end else if (r < 94) begin
        send_start(4'($urandom_range(9, 15)), rand_pc(), rand_byte(), rand_byte());
        stray_items++;
      end else begin
        // Break into a fetch with a start at a random point, then finish it.
        k = $urandom_range(0, operand_reads(md) - 1);
        send_start(md, rand_pc(), rand_byte(), rand_byte());
        for (int i = 0; i < k; i++) send_data(b[i]);
        send_start(4'($urandom_range(0, 15)), rand_pc(), rand_byte(), rand_byte());
        for (int i = k; i < operand_reads(md); i++) send_data(b[i]);
        fetches_done++;
        stray_items++;
      end
    end
    in_valid <= 1'b0;
    // Let the checker log the last accepted transaction before polling.
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    // Let anything spurious surface.
    repeat (10) @(posedge clk);

    $display("%0d transactions sent, %0d results checked", items_sent, results_seen);
    $display("%0d operand fetches completed, %0d out-of-phase or invalid transactions",
             fetches_done, stray_items);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
